@@ rtl/vrp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the view rotate/project unit.
package vrp_pkg;

   localparam int CoordFrac = 16;
   localparam int TrigFrac  = 14;
   localparam int QuoBits   = 31;
   localparam int IntBits   = QuoBits - CoordFrac;
   localparam int MagBits   = 45;
   localparam int ProdBits  = MagBits + 1;

   typedef enum logic [2:0] {
      OpRotZ      = 3'd0,
      OpRotYxProj = 3'd1,
      OpRotXyProj = 3'd2,
      OpRotVec    = 3'd3,
      OpProj      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CsrViewPosX = 3'd0,
      CsrViewPosY = 3'd1,
      CsrViewPosZ = 3'd2,
      CsrTrigX    = 3'd3,
      CsrTrigY    = 3'd4,
      CsrTrigZ    = 3'd5,
      CsrFocal    = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               div_zero;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] k0;
      logic signed [32:0] k1;
      logic signed [31:0] k2;
   } side_type;

   typedef struct packed {
      logic signed [33:0] a;
      logic signed [33:0] b;
      logic signed [15:0] c;
      logic signed [15:0] s;
   } rot_lane_type;

   typedef struct packed {
      rot_lane_type l0;
      rot_lane_type l1;
      side_type     side;
   } rot_in_type;

   typedef struct packed {
      logic signed [31:0] r0;
      logic signed [31:0] r1;
      side_type           side;
   } rot_out_type;

   typedef struct packed {
      logic                       proj;
      logic signed [ProdBits-1:0] px;
      logic signed [ProdBits-1:0] py;
      logic signed [31:0]         den;
      logic signed [31:0]         ox;
      logic signed [31:0]         oy;
      logic signed [31:0]         oz;
   } proj_type;

   typedef struct packed {
      logic [31:0]        rem;
      logic [QuoBits-1:0] quo;
      logic [QuoBits-1:0] dvd;
      logic               neg;
      logic               ovf;
      logic               pnz;
      logic               pneg;
   } div_lane_type;

   typedef struct packed {
      logic               proj;
      logic               dz;
      logic [31:0]        d;
      div_lane_type       lx;
      div_lane_type       ly;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
   } div_type;

   // a*c + b*s, round half up, saturate
   function automatic logic signed [31:0] rot_round(input logic signed [49:0] p,
                                                    input logic signed [49:0] q);
      logic signed [50:0] acc;
      logic signed [50:0] sh;
      acc = 51'(p) + 51'(q) + (51'sd1 <<< (TrigFrac - 1));
      sh  = acc >>> TrigFrac;
      if (sh > 51'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (sh < -51'sd2147483648) begin
         return 32'sh80000000;
      end
      return sh[31:0];
   endfunction

   function automatic div_lane_type div_lane_init(input logic signed [ProdBits-1:0] p,
                                                  input logic signed [31:0] den,
                                                  input logic [31:0] d);
      div_lane_type l;
      logic signed [ProdBits-1:0] pa;
      logic [MagBits-1:0] mag;
      pa     = p[ProdBits-1] ? -p : p;
      mag    = pa[MagBits-1:0];
      l.neg  = p[ProdBits-1] ^ den[31];
      l.pnz  = (p != '0);
      l.pneg = p[ProdBits-1];
      l.ovf  = ({2'b00, mag} >= {d, {IntBits{1'b0}}});
      l.rem  = 32'(mag[MagBits-1:IntBits]);
      l.dvd  = {mag[IntBits-1:0], {CoordFrac{1'b0}}};
      l.quo  = '0;
      return l;
   endfunction

   function automatic div_lane_type div_lane_step(input div_lane_type l,
                                                  input logic [31:0] d);
      div_lane_type n;
      logic [32:0] r2;
      logic ge;
      n     = l;
      r2    = {l.rem, l.dvd[QuoBits-1]};
      ge    = (r2 >= {1'b0, d});
      n.rem = ge ? 32'(r2 - {1'b0, d}) : r2[31:0];
      n.quo = {l.quo[QuoBits-2:0], ge};
      n.dvd = {l.dvd[QuoBits-2:0], 1'b0};
      return n;
   endfunction

   function automatic logic signed [31:0] div_lane_result(input div_lane_type l,
                                                          input logic dz);
      logic signed [31:0] q;
      q = $signed({1'b0, l.quo});
      if (dz) begin
         if (!l.pnz) begin
            return '0;
         end
         return l.pneg ? 32'sh80000000 : 32'sh7fffffff;
      end else if (l.ovf) begin
         return l.neg ? 32'sh80000000 : 32'sh7fffffff;
      end
      return l.neg ? -q : q;
   endfunction

endpackage

@@ rtl/vrp_rot.sv @@
// Two-lane rotation unit: multiply stage, then sum/round/saturate stage.
module vrp_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  vrp_pkg::rot_in_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vrp_pkg::rot_out_type out_data
);

   logic               mul_v_ff;
   logic               sum_v_ff;
   logic               mul_en;
   logic               sum_en;
   logic signed [49:0] pa0_ff, pb0_ff, pa1_ff, pb1_ff;
   logic signed [49:0] pa0_in, pb0_in, pa1_in, pb1_in;
   vrp_pkg::side_type  side_ff;
   vrp_pkg::rot_out_type out_ff;
   vrp_pkg::rot_out_type out_in;

   assign sum_en   = !sum_v_ff || out_ready;
   assign mul_en   = !mul_v_ff || sum_en;
   assign in_ready = mul_en;

   assign pa0_in = 50'(in_data.l0.a) * 50'(in_data.l0.c);
   assign pb0_in = 50'(in_data.l0.b) * 50'(in_data.l0.s);
   assign pa1_in = 50'(in_data.l1.a) * 50'(in_data.l1.c);
   assign pb1_in = 50'(in_data.l1.b) * 50'(in_data.l1.s);

   always_comb begin
      out_in.r0   = vrp_pkg::rot_round(pa0_ff, pb0_ff);
      out_in.r1   = vrp_pkg::rot_round(pa1_ff, pb1_ff);
      out_in.side = side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
      end else begin
         if (mul_en) begin
            mul_v_ff <= in_valid;
         end
         if (sum_en) begin
            sum_v_ff <= mul_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         pa0_ff  <= pa0_in;
         pb0_ff  <= pb0_in;
         pa1_ff  <= pa1_in;
         pb1_ff  <= pb1_in;
         side_ff <= in_data.side;
      end
      if (sum_en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = sum_v_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/vrp_div.sv @@
// Pipelined restoring divider for both projected lanes, with final saturation.
module vrp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vrp_pkg::proj_type     in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vrp_pkg::rsp_beat_type out_data
);

   localparam int Steps = vrp_pkg::QuoBits;

   vrp_pkg::div_type      stg_ff [Steps+1];
   vrp_pkg::div_type      prep_in;
   logic [Steps:0]        v_ff;
   logic [Steps:0]        en;
   logic                  out_v_ff;
   logic                  out_en;
   vrp_pkg::rsp_beat_type out_ff;
   vrp_pkg::rsp_beat_type out_in;
   logic signed [32:0]    den_w;
   logic signed [32:0]    den_abs;

   assign out_en   = !out_v_ff || out_ready;
   assign en[Steps] = !v_ff[Steps] || out_en;
   assign in_ready = en[0];

   always_comb begin
      den_w        = 33'(in_data.den);
      den_abs      = den_w[32] ? -den_w : den_w;
      prep_in.proj = in_data.proj;
      prep_in.d    = den_abs[31:0];
      prep_in.dz   = in_data.proj && (den_abs[31:0] == '0);
      prep_in.lx   = vrp_pkg::div_lane_init(in_data.px, in_data.den, den_abs[31:0]);
      prep_in.ly   = vrp_pkg::div_lane_init(in_data.py, in_data.den, den_abs[31:0]);
      prep_in.ox   = in_data.ox;
      prep_in.oy   = in_data.oy;
      prep_in.oz   = in_data.oz;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         stg_ff[0] <= prep_in;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      vrp_pkg::div_type step_in;
      assign en[i] = !v_ff[i] || en[i+1];
      always_comb begin
         step_in    = stg_ff[i];
         step_in.lx = vrp_pkg::div_lane_step(stg_ff[i].lx, stg_ff[i].d);
         step_in.ly = vrp_pkg::div_lane_step(stg_ff[i].ly, stg_ff[i].d);
      end
      always_ff @(posedge clock) begin
         if (en[i+1]) begin
            stg_ff[i+1] <= step_in;
         end
      end
   end

   always_comb begin
      if (stg_ff[Steps].proj) begin
         out_in.out_x = vrp_pkg::div_lane_result(stg_ff[Steps].lx, stg_ff[Steps].dz);
         out_in.out_y = vrp_pkg::div_lane_result(stg_ff[Steps].ly, stg_ff[Steps].dz);
      end else begin
         out_in.out_x = stg_ff[Steps].ox;
         out_in.out_y = stg_ff[Steps].oy;
      end
      out_in.out_z    = stg_ff[Steps].oz;
      out_in.div_zero = stg_ff[Steps].dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 0; i < Steps; i++) begin
            if (en[i+1]) begin
               v_ff[i+1] <= v_ff[i];
            end
         end
         if (out_en) begin
            out_v_ff <= v_ff[Steps];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/view_rotate_project_unit_top.sv @@
// Top level: config registers, operand select, two rotations, projection and divide.
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid/req_ready    req_beat (op code, x, y, z)
//   rsp_*        out   rsp_valid/rsp_ready    rsp_beat (x, y, z, div_zero)
//   csr_*        in    csr_we                 csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_ready stays high; the divider has 31 steps.
// Synchronous reset clears all valid bits and loads register defaults.
// Every stage holds while its successor is full and stalled; bubbles close up.
module view_rotate_project_unit_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vrp_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vrp_pkg::rsp_beat_type rsp_beat,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   logic signed [31:0] vpx_ff, vpy_ff, vpz_ff;
   logic [31:0]        trig_x_ff, trig_y_ff, trig_z_ff;
   logic [12:0]        focal_ff;

   logic signed [15:0] sx, cx, sy, cy, sz, cz;

   logic                 p0_v_ff, p1_v_ff, q_v_ff;
   vrp_pkg::rot_in_type  p0_ff, p0_in, p1_ff, p1_in;
   vrp_pkg::proj_type    q_ff, q_in;
   logic                 p0_en, p1_en, q_en;
   logic                 rot1_in_ready, rot1_out_valid;
   logic                 rot2_in_ready, rot2_out_valid;
   logic                 div_in_ready;
   vrp_pkg::rot_out_type rot1_out, rot2_out;

   logic signed [32:0] dx, ndx, dy, ydz;
   logic signed [32:0] numx, numy;
   logic signed [31:0] den;
   logic signed [46:0] pxw, pyw;

   assign sx = $signed(trig_x_ff[31:16]);
   assign cx = $signed(trig_x_ff[15:0]);
   assign sy = $signed(trig_y_ff[31:16]);
   assign cy = $signed(trig_y_ff[15:0]);
   assign sz = $signed(trig_z_ff[31:16]);
   assign cz = $signed(trig_z_ff[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vpx_ff    <= '0;
         vpy_ff    <= '0;
         vpz_ff    <= '0;
         trig_x_ff <= 32'd16384;
         trig_y_ff <= 32'd16384;
         trig_z_ff <= 32'd16384;
         focal_ff  <= 13'd160;
      end else if (csr_we) begin
         unique case (vrp_pkg::csr_idx_type'(csr_index))
            vrp_pkg::CsrViewPosX: vpx_ff    <= $signed(csr_wdata);
            vrp_pkg::CsrViewPosY: vpy_ff    <= $signed(csr_wdata);
            vrp_pkg::CsrViewPosZ: vpz_ff    <= $signed(csr_wdata);
            vrp_pkg::CsrTrigX:    trig_x_ff <= csr_wdata;
            vrp_pkg::CsrTrigY:    trig_y_ff <= csr_wdata;
            vrp_pkg::CsrTrigZ:    trig_z_ff <= csr_wdata;
            vrp_pkg::CsrFocal:    focal_ff  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // first rotation operands
   always_comb begin
      dx  = 33'(req_beat.in_x) - 33'(vpx_ff);
      ndx = 33'(vpx_ff) - 33'(req_beat.in_x);
      dy  = 33'(req_beat.in_y) - 33'(vpy_ff);
      ydz = 33'(req_beat.in_y) - 33'(vpz_ff);
      p0_in         = '0;
      p0_in.side.op = req_beat.req_type;
      unique case (vrp_pkg::op_type'(req_beat.req_type))
         vrp_pkg::OpRotZ: begin
            p0_in.l0 = '{a: 34'(dx),  b: 34'(dy), c: cz, s: sz};
            p0_in.l1 = '{a: 34'(ndx), b: 34'(dy), c: sz, s: cz};
         end
         vrp_pkg::OpRotYxProj: begin
            p0_in.l0 = '{a: 34'(req_beat.in_y), b: -34'(req_beat.in_z), c: cx, s: sx};
            p0_in.l1 = '{a: 34'(req_beat.in_y), b: 34'(req_beat.in_z),  c: sx, s: cx};
            p0_in.side.k0 = req_beat.in_x;
         end
         vrp_pkg::OpRotXyProj: begin
            p0_in.l0 = '{a: 34'(req_beat.in_x),  b: 34'(req_beat.in_z), c: cy, s: sy};
            p0_in.l1 = '{a: -34'(req_beat.in_x), b: 34'(req_beat.in_z), c: sy, s: cy};
            p0_in.side.k0 = req_beat.in_y;
         end
         vrp_pkg::OpRotVec: begin
            p0_in.l0 = '{a: 34'(req_beat.in_y),  b: 34'(req_beat.in_z), c: cx, s: sx};
            p0_in.l1 = '{a: -34'(req_beat.in_y), b: 34'(req_beat.in_z), c: sx, s: cx};
            p0_in.side.k0 = req_beat.in_x;
         end
         vrp_pkg::OpProj: begin
            p0_in.side.k0 = req_beat.in_x;
            p0_in.side.k1 = ydz;
            p0_in.side.k2 = req_beat.in_z;
         end
         default: ;
      endcase
   end

   assign p0_en     = !p0_v_ff || rot1_in_ready;
   assign req_ready = p0_en;

   vrp_rot u_rot1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p0_v_ff),
      .in_ready  (rot1_in_ready),
      .in_data   (p0_ff),
      .out_valid (rot1_out_valid),
      .out_ready (p1_en),
      .out_data  (rot1_out)
   );

   // second rotation operands
   always_comb begin
      p1_in      = '0;
      p1_in.side = rot1_out.side;
      unique case (vrp_pkg::op_type'(rot1_out.side.op))
         vrp_pkg::OpRotZ: begin
            p1_in.side.k0 = rot1_out.r0;
            p1_in.side.k1 = 33'(rot1_out.r1);
         end
         vrp_pkg::OpRotYxProj: begin
            p1_in.l0 = '{a: 34'(rot1_out.side.k0), b: -34'(rot1_out.r1), c: cy, s: sy};
            p1_in.l1 = '{a: 34'(rot1_out.side.k0), b: 34'(rot1_out.r1),  c: sy, s: cy};
            p1_in.side.k1 = 33'(rot1_out.r0);
         end
         vrp_pkg::OpRotXyProj: begin
            p1_in.l0 = '{a: 34'(rot1_out.side.k0),  b: 34'(rot1_out.r1), c: cx, s: sx};
            p1_in.l1 = '{a: -34'(rot1_out.side.k0), b: 34'(rot1_out.r1), c: sx, s: cx};
            p1_in.side.k0 = rot1_out.r0;
         end
         vrp_pkg::OpRotVec: begin
            p1_in.l0 = '{a: 34'(rot1_out.side.k0),  b: 34'(rot1_out.r1), c: cy, s: sy};
            p1_in.l1 = '{a: -34'(rot1_out.side.k0), b: 34'(rot1_out.r1), c: sy, s: cy};
            p1_in.side.k1 = 33'(rot1_out.r0);
         end
         default: ;
      endcase
   end

   assign p1_en = !p1_v_ff || rot2_in_ready;

   vrp_rot u_rot2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p1_v_ff),
      .in_ready  (rot2_in_ready),
      .in_data   (p1_ff),
      .out_valid (rot2_out_valid),
      .out_ready (q_en),
      .out_data  (rot2_out)
   );

   // projection select and focal scaling
   always_comb begin
      numx = '0;
      numy = '0;
      den  = '0;
      q_in = '0;
      unique case (vrp_pkg::op_type'(rot2_out.side.op))
         vrp_pkg::OpRotZ: begin
            q_in.ox = rot2_out.side.k0;
            q_in.oy = rot2_out.side.k1[31:0];
         end
         vrp_pkg::OpRotYxProj: begin
            q_in.proj = 1'b1;
            numx = 33'(rot2_out.r0);
            numy = 33'(rot2_out.r1);
            den  = rot2_out.side.k1[31:0];
         end
         vrp_pkg::OpRotXyProj: begin
            q_in.proj = 1'b1;
            numx = 33'(rot2_out.side.k0);
            numy = 33'(rot2_out.r1);
            den  = rot2_out.r0;
         end
         vrp_pkg::OpRotVec: begin
            q_in.ox = rot2_out.r0;
            q_in.oy = rot2_out.side.k1[31:0];
            q_in.oz = rot2_out.r1;
         end
         vrp_pkg::OpProj: begin
            q_in.proj = 1'b1;
            numx = 33'(rot2_out.side.k0);
            numy = rot2_out.side.k1;
            den  = rot2_out.side.k2;
         end
         default: ;
      endcase
      pxw = 47'(numx) * 47'($signed({1'b0, focal_ff}));
      pyw = 47'(numy) * 47'($signed({1'b0, focal_ff}));
      q_in.px  = pxw[vrp_pkg::ProdBits-1:0];
      q_in.py  = pyw[vrp_pkg::ProdBits-1:0];
      q_in.den = den;
   end

   assign q_en = !q_v_ff || div_in_ready;

   vrp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_v_ff),
      .in_ready  (div_in_ready),
      .in_data   (q_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         q_v_ff  <= 1'b0;
      end else begin
         if (p0_en) begin
            p0_v_ff <= req_valid;
         end
         if (p1_en) begin
            p1_v_ff <= rot1_out_valid;
         end
         if (q_en) begin
            q_v_ff <= rot2_out_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p0_en) begin
         p0_ff <= p0_in;
      end
      if (p1_en) begin
         p1_ff <= p1_in;
      end
      if (q_en) begin
         q_ff <= q_in;
      end
   end

   a_dz_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.div_zero |->
         (rsp_beat.out_x == 32'sh7fffffff || rsp_beat.out_x == 32'sh80000000 ||
          rsp_beat.out_x == '0))
      else $error("div_zero beat with unsaturated out_x");

   a_dz_no_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.div_zero |-> rsp_beat.out_z == '0)
      else $error("div_zero beat with nonzero out_z");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
